FILE: rtl/core/gfba_pkg.sv
// shared types and constants for the grouped free block allocator
// no dependencies; used by the link row memory and the top level
package gfba_pkg;

  // fixed field widths
  localparam int BLK_W   = 10;
  localparam int TOTAL_W = 11;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_LOAD
  } state_t;

  // pending link row operation
  typedef enum logic {
    OP_LOAD,
    OP_SPILL
  } row_op_t;

  // link memory access request
  typedef struct packed {
    logic wr;
    logic rd;
  } link_req_t;

endpackage

FILE: rtl/core/gfba_link_ram.sv
// link row memory: one full group of block numbers per row
// single port, registered read; depends on gfba_pkg
module gfba_link_ram #(
  parameter int ROWS   = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 160
) (
  input  logic                clk,
  input  gfba_pkg::link_req_t req,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [DATA_W-1:0]   wr_data,
  output logic [DATA_W-1:0]   rd_data
);

  logic [DATA_W-1:0] mem [ROWS];
  logic [DATA_W-1:0] rd_data_r;

  // row write
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wr_data;
    end
  end

  // registered row read
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/grouped_free_block_allocator_unit.sv
// grouped free block allocator: register stack of the current group plus a link row memory
// depends on gfba_pkg and gfba_link_ram
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+------------------
//  in      | input     | in_mode, in_block_number                     | in_valid/in_stall
//  out     | output    | out_granted_block, out_status, out_free_total| out_valid/out_stall
//
// a transaction's result is registered at the edge that accepts it
// an allocate that hands out the group's link block goes through accept, link row
//   read, then group load from the registered row; a free onto a full stack goes through
//   accept, then link row write (row address reduction modulo BLOCK_COUNT sits in between)
// synchronous active-low reset clears the stack, top index, count and control; no clear pass
// in_stall is high while a row access is under way or a result waits on out_stall
module grouped_free_block_allocator_unit #(
  parameter int GROUP_SIZE  = 16,
  parameter int BLOCK_COUNT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [gfba_pkg::BLK_W-1:0]   in_block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gfba_pkg::BLK_W-1:0]   out_granted_block,
  output logic                         out_status,
  output logic [gfba_pkg::TOTAL_W-1:0] out_free_total
);

  localparam int BLK_W    = gfba_pkg::BLK_W;
  localparam int TOP_W    = $clog2(GROUP_SIZE);
  localparam int CNT_W    = $clog2(BLOCK_COUNT + 1);
  localparam int ROW_W    = $clog2(BLOCK_COUNT);
  localparam int DATA_W   = GROUP_SIZE * BLK_W;
  localparam int RECIP_SH = 2 * BLK_W;
  localparam int PROD_W   = RECIP_SH + BLK_W;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((1 << RECIP_SH) + BLOCK_COUNT - 1) / BLOCK_COUNT);
  localparam logic [TOP_W-1:0] TOP_LAST = TOP_W'(GROUP_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(BLOCK_COUNT);

  // registers
  gfba_pkg::state_t  state_r, state_nxt;
  gfba_pkg::row_op_t op_r, op_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BLK_W-1:0]  pend_blk_r, pend_blk_nxt;
  logic [BLK_W-1:0]  quot_r, quot_nxt;
  logic [BLK_W-1:0]  stack_r [GROUP_SIZE];
  logic              out_valid_r;
  logic [BLK_W-1:0]  granted_r;
  logic              status_r;
  logic [gfba_pkg::TOTAL_W-1:0] total_r;

  // combinational
  logic                accept;
  logic                is_free;
  logic [BLK_W-1:0]    top_entry;
  logic [BLK_W-1:0]    sel_blk;
  logic [PROD_W-1:0]   prod;
  logic [BLK_W-1:0]    quot_bc;
  logic [BLK_W-1:0]    rem;
  logic [ROW_W-1:0]    row_addr;
  logic [DATA_W-1:0]   spill_row;
  logic [DATA_W-1:0]   load_row;
  logic                stack_we;
  logic [TOP_W-1:0]    stack_wa;
  logic [BLK_W-1:0]    stack_wd;
  logic                load_all;
  gfba_pkg::link_req_t req;
  logic [BLK_W-1:0]    res_granted;
  logic                res_status;

  assign accept    = in_valid && !in_stall;
  assign is_free   = (in_mode == gfba_pkg::MODE_FREE);
  assign top_entry = stack_r[top_r];
  assign in_stall  = (state_r != gfba_pkg::ST_IDLE) || (out_valid_r && out_stall);

  // quotient of the row's block number by BLOCK_COUNT, via reciprocal
  assign sel_blk  = is_free ? in_block_number : top_entry;
  assign prod     = PROD_W'(sel_blk) * RECIP;
  assign quot_nxt = prod[PROD_W-1:RECIP_SH];

  // remainder gives the link row address
  assign quot_bc  = BLK_W'(32'(quot_r) * 32'(BLOCK_COUNT));
  assign rem      = pend_blk_r - quot_bc;
  assign row_addr = ROW_W'(rem);

  // pack a full group into a link row
  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      spill_row[i*BLK_W +: BLK_W] = stack_r[i];
    end
  end

  // sequencer: next state, stack and count updates
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    top_nxt      = top_r;
    count_nxt    = count_r;
    pend_blk_nxt = pend_blk_r;
    stack_we     = 1'b0;
    stack_wa     = top_r;
    stack_wd     = in_block_number;
    load_all     = 1'b0;
    req          = '0;
    res_granted  = '0;
    res_status   = gfba_pkg::STATUS_OK;
    unique case (state_r)
      gfba_pkg::ST_IDLE: begin
        if (accept) begin
          pend_blk_nxt = sel_blk;
          if (!is_free) begin
            if (count_r == '0) begin
              res_status = gfba_pkg::STATUS_FULL;
            end else begin
              res_granted = top_entry;
              count_nxt   = count_r - CNT_W'(1);
              if (top_r == TOP_LAST) begin
                op_nxt    = gfba_pkg::OP_LOAD;
                state_nxt = gfba_pkg::ST_ROW;
              end else begin
                top_nxt = top_r + TOP_W'(1);
              end
            end
          end else begin
            if (count_r < CNT_MAX) begin
              count_nxt = count_r + CNT_W'(1);
            end
            if (top_r == '0) begin
              op_nxt    = gfba_pkg::OP_SPILL;
              state_nxt = gfba_pkg::ST_ROW;
            end else begin
              top_nxt  = top_r - TOP_W'(1);
              stack_we = 1'b1;
              stack_wa = top_r - TOP_W'(1);
            end
          end
        end
      end
      gfba_pkg::ST_ROW: begin
        if (op_r == gfba_pkg::OP_LOAD) begin
          req.rd    = 1'b1;
          state_nxt = gfba_pkg::ST_LOAD;
        end else begin
          // spill the full group, freed block starts a new group
          req.wr    = 1'b1;
          stack_we  = 1'b1;
          stack_wa  = TOP_LAST;
          stack_wd  = pend_blk_r;
          top_nxt   = TOP_LAST;
          state_nxt = gfba_pkg::ST_IDLE;
        end
      end
      gfba_pkg::ST_LOAD: begin
        load_all  = 1'b1;
        top_nxt   = '0;
        state_nxt = gfba_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gfba_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfba_pkg::ST_IDLE;
      op_r    <= gfba_pkg::OP_LOAD;
      top_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      top_r   <= top_nxt;
      count_r <= count_nxt;
    end
  end

  // pending row request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_blk_r <= pend_blk_nxt;
      quot_r     <= quot_nxt;
    end
  end

  // current group stack
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GROUP_SIZE; i++) begin
        stack_r[i] <= '0;
      end
    end else if (load_all) begin
      for (int i = 0; i < GROUP_SIZE; i++) begin
        stack_r[i] <= load_row[i*BLK_W +: BLK_W];
      end
    end else if (stack_we) begin
      stack_r[stack_wa] <= stack_wd;
    end
  end

  // link rows
  gfba_link_ram #(
    .ROWS   (BLOCK_COUNT),
    .ADDR_W (ROW_W),
    .DATA_W (DATA_W)
  ) u_link_ram (
    .clk     (clk),
    .req     (req),
    .addr    (row_addr),
    .wr_data (spill_row),
    .rd_data (load_row)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      granted_r <= res_granted;
      status_r  <= res_status;
      total_r   <= gfba_pkg::TOTAL_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = granted_r;
  assign out_status        = status_r;
  assign out_free_total    = total_r;

`ifndef ASSERT_OFF
  // handing out the link block must start a row load
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_free && count_r != '0 && top_r == TOP_LAST
      |=> state_r == gfba_pkg::ST_ROW && op_r == gfba_pkg::OP_LOAD)
    else $error("group load not started");

  // group load only follows a row read
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gfba_pkg::ST_LOAD |-> $past(req.rd))
    else $error("group load without row read");

  // count never passes the block total
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("free count above block total");

  // memory port never read and written together
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr && req.rd))
    else $error("link memory read and write in one cycle");

  // a full result grants nothing
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == gfba_pkg::STATUS_FULL |-> granted_r == '0)
    else $error("disk full result with a granted block");
`endif

endmodule

FILE: test/grouped_free_block_allocator_unit_tb.sv
// self-checking testbench for grouped_free_block_allocator_unit
// depends on gfba_pkg and the allocator rtl; a directed table, then random traffic
// checked against an in-bench model of the grouped free list
module grouped_free_block_allocator_unit_tb;

  localparam int BLK_W       = gfba_pkg::BLK_W;
  localparam int TOTAL_W     = gfba_pkg::TOTAL_W;
  localparam int GRP         = 16;
  localparam int NBLK        = 1024;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [BLK_W-1:0]   granted;
    logic               status;
    logic [TOTAL_W-1:0] total;
  } result_t;

  typedef struct packed {
    logic             mode;
    logic [BLK_W-1:0] blk;
    bit               typed;
    result_t          res;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [BLK_W-1:0]   in_block_number;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BLK_W-1:0]   out_granted_block;
  logic               out_status;
  logic [TOTAL_W-1:0] out_free_total;

  // free list model: current group, top index, count and link rows
  logic [BLK_W-1:0]   model_stack [GRP];
  int                 model_top;
  logic [TOTAL_W-1:0] model_count;
  logic [BLK_W-1:0]   link_rows [NBLK][GRP];
  bit                 row_written [NBLK];

  result_t     due_results [$];
  plan_row_t   plan [$];
  result_t     head;
  int          errors = 0;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_count;

  grouped_free_block_allocator_unit #(
    .GROUP_SIZE (GRP),
    .BLOCK_COUNT(NBLK)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_block(out_granted_block),
    .out_status       (out_status),
    .out_free_total   (out_free_total)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // advance the model by one request and return its result
  task automatic apply_request(input logic m, input logic [BLK_W-1:0] b, output result_t r);
    logic [BLK_W-1:0] g;
    g = '0;
    r.status = gfba_pkg::STATUS_OK;
    if (m == gfba_pkg::MODE_ALLOC) begin
      if (model_count == 0) begin
        r.status = gfba_pkg::STATUS_FULL;
      end else begin
        g = model_stack[model_top];
        // handing out the link block pulls in the next group
        if (model_top == GRP - 1) begin
          for (int i = 0; i < GRP; i++) model_stack[i] = link_rows[g % NBLK][i];
          model_top = 0;
        end else begin
          model_top++;
        end
        model_count--;
      end
    end else begin
      // full stack spills into the freed block's row
      if (model_top == 0) begin
        for (int i = 0; i < GRP; i++) link_rows[b % NBLK][i] = model_stack[i];
        row_written[b % NBLK] = 1'b1;
        model_top = GRP - 1;
      end else begin
        model_top--;
      end
      model_stack[model_top] = b;
      if (model_count < NBLK) model_count++;
    end
    r.granted = g;
    r.total   = model_count;
  endtask

  // present one transaction, hold it until taken, then record its expectation
  task automatic send_request(input logic m, input logic [BLK_W-1:0] b, input bit typed,
                              input result_t typed_res);
    result_t r;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_block_number <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    apply_request(m, b, r);
    due_results.push_back(typed ? typed_res : r);
  endtask

  function automatic logic [BLK_W-1:0] pick_block();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return BLK_W'($urandom());
    endcase
  endfunction

  // random request; an allocate that would load a never-written row becomes a free
  task automatic send_random(input int alloc_pct);
    logic m;
    m = ($urandom_range(0, 99) < alloc_pct) ? gfba_pkg::MODE_ALLOC : gfba_pkg::MODE_FREE;
    if (m == gfba_pkg::MODE_ALLOC && model_count != 0 && model_top == GRP - 1 &&
        !row_written[model_stack[GRP-1] % NBLK])
      m = gfba_pkg::MODE_FREE;
    send_request(m, pick_block(), 1'b0, '0);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic m, input logic [BLK_W-1:0] b, input bit typed,
                         input logic [BLK_W-1:0] g, input logic s, input logic [TOTAL_W-1:0] t);
    plan_row_t row;
    row.mode        = m;
    row.blk         = b;
    row.typed       = typed;
    row.res.granted = g;
    row.res.status  = s;
    row.res.total   = t;
    plan.push_back(row);
  endtask

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual granted %0d status %0d total %0d",
                 $time, out_granted_block, out_status, out_free_total);
        errors++;
      end else begin
        head = due_results.pop_front();
        if (out_granted_block !== head.granted) begin
          $display("%0t granted_block mismatch: expected %0d, actual %0d",
                   $time, head.granted, out_granted_block);
          errors++;
        end
        if (out_status !== head.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, head.status, out_status);
          errors++;
        end
        if (out_free_total !== head.total) begin
          $display("%0t free_total mismatch: expected %0d, actual %0d",
                   $time, head.total, out_free_total);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // main sequence
  initial begin
    int extra;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = gfba_pkg::MODE_ALLOC;
    in_block_number = '0;
    for (int i = 0; i < GRP; i++) model_stack[i] = '0;
    for (int i = 0; i < NBLK; i++) row_written[i] = 1'b0;
    model_top   = 0;
    model_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: disk full after reset, first frees, link block handout, spill and reload
    add_row(gfba_pkg::MODE_ALLOC, 10'd0,    1'b1, 10'd0,    gfba_pkg::STATUS_FULL, 11'd0);
    add_row(gfba_pkg::MODE_ALLOC, 10'd1023, 1'b1, 10'd0,    gfba_pkg::STATUS_FULL, 11'd0);
    add_row(gfba_pkg::MODE_FREE,  10'd0,    1'b1, 10'd0,    gfba_pkg::STATUS_OK,   11'd1);
    add_row(gfba_pkg::MODE_FREE,  10'd1023, 1'b1, 10'd0,    gfba_pkg::STATUS_OK,   11'd2);
    add_row(gfba_pkg::MODE_ALLOC, 10'd0,    1'b1, 10'd1023, gfba_pkg::STATUS_OK,   11'd1);
    add_row(gfba_pkg::MODE_ALLOC, 10'd1023, 1'b1, 10'd0,    gfba_pkg::STATUS_OK,   11'd0);
    add_row(gfba_pkg::MODE_ALLOC, 10'd0,    1'b1, 10'd0,    gfba_pkg::STATUS_FULL, 11'd0);
    for (int i = 0; i <= GRP; i++)
      add_row(gfba_pkg::MODE_FREE, BLK_W'(i * 61 + 5), 1'b0, '0, '0, '0);
    add_row(gfba_pkg::MODE_ALLOC, 10'd0, 1'b0, '0, '0, '0);
    foreach (plan[i]) send_request(plan[i].mode, plan[i].blk, plan[i].typed, plan[i].res);

    // mixed traffic near empty: disk full, group loads and spills
    repeat (180) send_random(55);

    // sender holds off until the block has caught up
    wait_for_results();

    // fill to the block total and keep freeing past saturation
    extra = 0;
    while (extra < 40) begin
      send_random(4);
      if (model_count == NBLK) extra++;
    end

    // closing stretch with no idling on either side
    idle_on = 1'b0;
    repeat (100) send_random(70);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
